// File: hw/rtl/bcewl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcewl_pkg
// Shared types, widths and the softplus table for the BCE-with-logits loss unit.
// ----------------------------------------------------------------------------
package bcewl_pkg;

  localparam int LOGIT_W  = 16;
  localparam int TARGET_W = 9;
  localparam int MODE_W   = 2;
  localparam int LOSS_W   = 16;
  localparam int ACC_W    = 48;
  localparam int CNT_W    = 32;
  localparam int OUT_W    = 40;

  localparam int SOFTPLUS_TABLE_DEPTH = 256;
  localparam int SP_STORED            = 128;
  localparam int SP_IDX_W             = $clog2(SP_STORED);
  localparam int SP_K_W               = LOGIT_W - 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int DIV_STEPS = ACC_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;

  localparam logic [TARGET_W-1:0] TARGET_ONE = 9'd256;

  typedef enum logic [1:0] {
    KIND_ELEM,
    KIND_ACC,
    KIND_SUM_LAST,
    KIND_MEAN_LAST
  } item_kind_t;

  typedef struct packed {
    logic [LOSS_W-1:0] loss;
    item_kind_t        kind;
  } q_entry_t;

  localparam logic [7:0] SP_TABLE [SP_STORED] = '{
    8'd177, 8'd170, 8'd162, 8'd155, 8'd147, 8'd141, 8'd134, 8'd128, 8'd121, 8'd115,
    8'd110, 8'd104, 8'd99,  8'd94,  8'd89,  8'd85,  8'd80,  8'd76,  8'd72,  8'd68,
    8'd64,  8'd61,  8'd58,  8'd55,  8'd52,  8'd49,  8'd46,  8'd43,  8'd41,  8'd39,
    8'd37,  8'd34,  8'd32,  8'd31,  8'd29,  8'd27,  8'd26,  8'd24,  8'd23,  8'd21,
    8'd20,  8'd19,  8'd18,  8'd17,  8'd16,  8'd15,  8'd14,  8'd13,  8'd12,  8'd12,
    8'd11,  8'd10,  8'd10,  8'd9,   8'd9,   8'd8,   8'd8,   8'd7,   8'd7,   8'd6,
    8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,   8'd3,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  // softplus(-|x|) in Q.8, indexed by |x| in steps of 1/16
  function automatic logic [7:0] softplus(input logic [LOGIT_W-1:0] mag);
    logic [SP_K_W-1:0] k;
    logic [7:0]        res;
    k = mag[LOGIT_W-1:4];
    if (32'(k) >= SOFTPLUS_TABLE_DEPTH || 32'(k) >= SP_STORED) begin
      res = 8'd0;
    end else begin
      res = SP_TABLE[k[SP_IDX_W-1:0]];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bcewl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcewl channel interfaces
// Valid/ready channels for element requests, results and configuration.
// ----------------------------------------------------------------------------
interface bcewl_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [bcewl_pkg::LOGIT_W-1:0] logit_value;
  logic [bcewl_pkg::TARGET_W-1:0] target_value;
  logic                          last_item;
  modport source (output valid, output logit_value, output target_value,
                  output last_item, input ready);
  modport sink   (input valid, input logit_value, input target_value,
                  input last_item, output ready);
endinterface

interface bcewl_out_if;
  logic                         valid;
  logic                         ready;
  logic [bcewl_pkg::OUT_W-1:0]  loss_value;
  logic                         is_reduced;
  modport source (output valid, output loss_value, output is_reduced, input ready);
  modport sink   (input valid, input loss_value, input is_reduced, output ready);
endinterface

interface bcewl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bcewl_pkg::MODE_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bcewl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcewl_front
// Accepts element requests, forms the element loss and classifies the request.
// ----------------------------------------------------------------------------
module bcewl_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  bcewl_in_if.sink                 in_ch,
  bcewl_cfg_if.sink                cfg_ch,
  output bcewl_pkg::q_entry_t      push_data,
  output logic                     push,
  input  wire logic                q_full
);
  import bcewl_pkg::*;

  logic                        stage_valid_r;
  logic signed [LOGIT_W-1:0]   x_r;
  logic [TARGET_W-1:0]         y_r;
  item_kind_t                  kind_r;
  logic [MODE_W-1:0]           mode_r;
  item_kind_t                  kind_nxt;

  logic [TARGET_W-1:0]         y_sat;
  logic signed [25:0]          xe;
  logic signed [25:0]          ye;
  logic signed [25:0]          prod;
  logic signed [25:0]          pos;
  logic signed [25:0]          term;
  logic [LOGIT_W-1:0]          mag;
  logic [LOSS_W:0]             loss_sum;

  assign cfg_ch.ready = 1'b1;
  assign push         = stage_valid_r && !q_full;
  assign in_ch.ready  = !stage_valid_r || push;

  always_comb begin
    case (mode_r)
      MODE_NONE: kind_nxt = KIND_ELEM;
      MODE_MEAN: kind_nxt = in_ch.last_item ? KIND_MEAN_LAST : KIND_ACC;
      default:   kind_nxt = in_ch.last_item ? KIND_SUM_LAST : KIND_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      mode_r        <= MODE_NONE;
    end else begin
      if (cfg_ch.valid) begin
        mode_r <= cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        stage_valid_r <= 1'b1;
      end else if (push) begin
        stage_valid_r <= 1'b0;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      x_r    <= in_ch.logit_value;
      y_r    <= in_ch.target_value;
      kind_r <= kind_nxt;
    end
  end

  // max(x,0)*256 - x*y in Q.16, never negative
  always_comb begin
    y_sat    = (y_r > TARGET_ONE) ? TARGET_ONE : y_r;
    xe       = 26'(x_r);
    ye       = $signed(26'(y_sat));
    prod     = xe * ye;
    pos      = (x_r > 0) ? (xe <<< 8) : 26'sd0;
    term     = pos - prod;
    mag      = x_r[LOGIT_W-1] ? LOGIT_W'(-xe) : LOGIT_W'(xe);
    loss_sum = {1'b0, term[23:8]} + (LOSS_W+1)'(softplus(mag));
  end

  assign push_data.loss = loss_sum[LOSS_W-1:0];
  assign push_data.kind = kind_r;

endmodule
`default_nettype wire

// File: hw/rtl/bcewl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcewl_queue
// Short FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module bcewl_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  bcewl_pkg::q_entry_t  push_data,
  input  wire logic            push,
  output logic                 full,
  output bcewl_pkg::q_entry_t  head,
  output logic                 head_valid,
  input  wire logic            pop
);
  import bcewl_pkg::*;

  q_entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     count_r;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bcewl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcewl_div
// Restoring divider, one quotient bit per cycle, for the run mean.
// ----------------------------------------------------------------------------
module bcewl_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bcewl_pkg::ACC_W-1:0] dividend,
  input  wire logic [bcewl_pkg::CNT_W-1:0] divisor,
  output logic                           busy,
  output logic [bcewl_pkg::ACC_W-1:0]    quotient
);
  import bcewl_pkg::*;

  logic              busy_r;
  logic [DIV_CW-1:0] step_r;
  logic [ACC_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;

  assign busy     = busy_r;
  assign quotient = quo_r;
  assign rem_sh   = {rem_r, quo_r[ACC_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == DIV_CW'(DIV_STEPS-1)) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!rem_diff[CNT_W]) begin
        rem_r <= rem_diff[CNT_W-1:0];
        quo_r <= {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[CNT_W-1:0];
        quo_r <= {quo_r[ACC_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bcewl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcewl_back
// Executes queued requests: per-element output, run accumulation, sum and mean.
// ----------------------------------------------------------------------------
module bcewl_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  bcewl_pkg::q_entry_t  head,
  input  wire logic            head_valid,
  output logic                 pop,
  bcewl_out_if.source          out_ch
);
  import bcewl_pkg::*;

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t            state_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  loss_r;
  logic              reduced_r;
  logic [ACC_W-1:0]  acc_r;
  logic [CNT_W-1:0]  cnt_r;

  logic              out_free;
  logic [ACC_W:0]    acc_add;
  logic [ACC_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  cnt_inc;
  logic              div_start;
  logic              div_busy;
  logic [ACC_W-1:0]  div_quo;

  function automatic logic [OUT_W-1:0] sat_out(input logic [ACC_W-1:0] v);
    return (|v[ACC_W-1:OUT_W]) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign acc_add  = {1'b0, acc_r} + (ACC_W+1)'(head.loss);
  assign acc_sum  = acc_add[ACC_W] ? {ACC_W{1'b1}} : acc_add[ACC_W-1:0];
  assign cnt_inc  = (&cnt_r) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    pop = 1'b0;
    if (state_r == ST_IDLE && head_valid) begin
      case (head.kind)
        KIND_ACC:       pop = 1'b1;
        KIND_MEAN_LAST: pop = 1'b1;
        default:        pop = out_free;
      endcase
    end
  end

  assign div_start = pop && (head.kind == KIND_MEAN_LAST);

  bcewl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (cnt_inc),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.loss_value = loss_r;
  assign out_ch.is_reduced = reduced_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            case (head.kind)
              KIND_ELEM: begin
                out_valid_r <= 1'b1;
                loss_r      <= OUT_W'(head.loss);
                reduced_r   <= 1'b0;
              end
              KIND_ACC: begin
                acc_r <= acc_sum;
                cnt_r <= cnt_inc;
              end
              KIND_SUM_LAST: begin
                out_valid_r <= 1'b1;
                loss_r      <= sat_out(acc_sum);
                reduced_r   <= 1'b1;
                acc_r       <= '0;
                cnt_r       <= '0;
              end
              default: begin
                state_r <= ST_DIV;
                acc_r   <= '0;
                cnt_r   <= '0;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (!div_busy && out_free) begin
            out_valid_r <= 1'b1;
            loss_r      <= sat_out(div_quo);
            reduced_r   <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy)
    else $error("divider did not start");

  a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> !pop)
    else $error("request taken while dividing");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> cnt_inc != '0)
    else $error("mean started with zero count");

endmodule
`default_nettype wire

// File: hw/rtl/bce_with_logits_loss_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bce_with_logits_loss_unit
// Streaming binary cross-entropy with logits, per element or reduced over a run.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the queue has room; the queue fills when
// the result channel stalls or at the last request of a run mean, where the 48-step
// divider yields one quotient bit per cycle and holds the back end meanwhile.
// Reset: synchronous, active low; clears mode, queue, accumulator and count.
// ----------------------------------------------------------------------------
module bce_with_logits_loss_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bcewl_in_if.sink    in_ch,
  bcewl_out_if.source out_ch,
  bcewl_cfg_if.sink   cfg_ch
);
  import bcewl_pkg::*;

  q_entry_t push_data;
  q_entry_t head;
  logic     push;
  logic     q_full;
  logic     head_valid;
  logic     pop;

  bcewl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .push_data (push_data),
    .push      (push),
    .q_full    (q_full)
  );

  bcewl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push       (push),
    .full       (q_full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  bcewl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// File: test/bcewl_loss_checker.sv
// ----------------------------------------------------------------------------
// bcewl_loss_checker
// Watches the request, result and configuration channels of the loss unit.
// It keeps its own copy of the mode, run total and run length, predicts each
// result from the accepted requests and compares the results in order.
// ----------------------------------------------------------------------------
module bcewl_loss_checker (
  input  logic        clk,
  input  logic        rst_n,
  bcewl_in_if         req,
  bcewl_out_if        res,
  bcewl_cfg_if        cfg,
  input  logic        end_of_run,
  output int unsigned fail_count,
  output int unsigned losses_due
);
  import bcewl_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] loss_value;
    logic             is_reduced;
  } loss_result_t;

  localparam logic [ACC_W-1:0] ACC_CEIL = {ACC_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_CEIL = {CNT_W{1'b1}};
  localparam logic [ACC_W-1:0] OUT_CEIL = {{(ACC_W-OUT_W){1'b0}}, {OUT_W{1'b1}}};
  localparam int               SP_NONZERO = 100;

  // round(256*ln(1+exp(-k/16))); zero from step 100 on
  localparam logic [7:0] SOFTPLUS_STEPS [SP_NONZERO] = '{
    8'd177, 8'd170, 8'd162, 8'd155, 8'd147, 8'd141, 8'd134, 8'd128, 8'd121, 8'd115,
    8'd110, 8'd104, 8'd99,  8'd94,  8'd89,  8'd85,  8'd80,  8'd76,  8'd72,  8'd68,
    8'd64,  8'd61,  8'd58,  8'd55,  8'd52,  8'd49,  8'd46,  8'd43,  8'd41,  8'd39,
    8'd37,  8'd34,  8'd32,  8'd31,  8'd29,  8'd27,  8'd26,  8'd24,  8'd23,  8'd21,
    8'd20,  8'd19,  8'd18,  8'd17,  8'd16,  8'd15,  8'd14,  8'd13,  8'd12,  8'd12,
    8'd11,  8'd10,  8'd10,  8'd9,   8'd9,   8'd8,   8'd8,   8'd7,   8'd7,   8'd6,
    8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,   8'd3,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1
  };

  loss_result_t      pending_losses[$];
  logic [MODE_W-1:0] mode;
  logic [ACC_W-1:0]  run_total;
  logic [CNT_W-1:0]  run_items;
  int unsigned       fails = 0;
  bit                leftovers_flagged = 1'b0;

  function automatic logic [LOSS_W-1:0] pair_loss(input logic signed [LOGIT_W-1:0] x,
                                                   input logic [TARGET_W-1:0] y);
    longint     xs;
    longint     ys;
    longint     term;
    longint     mag;
    logic [7:0] sp;
    xs   = x;
    ys   = (y > TARGET_ONE) ? longint'(TARGET_ONE) : longint'(y);
    term = ((xs > 0) ? xs * 256 : 0) - xs * ys;
    mag  = (xs < 0) ? -xs : xs;
    sp   = ((mag >> 4) < SP_NONZERO) ? SOFTPLUS_STEPS[mag >> 4] : 8'd0;
    return LOSS_W'((term >> 8) + longint'(sp));
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] loss mismatch: %s", $time, what);
    fails++;
  endtask

  task automatic predict_request(input logic signed [LOGIT_W-1:0] x,
                                 input logic [TARGET_W-1:0] y, input logic last);
    logic [LOSS_W-1:0] loss;
    logic [ACC_W-1:0]  total;
    loss = pair_loss(x, y);
    if (mode == MODE_NONE) begin
      pending_losses.push_back('{OUT_W'(loss), 1'b0});
    end else begin
      if (run_total > ACC_CEIL - ACC_W'(loss)) run_total = ACC_CEIL;
      else run_total = run_total + ACC_W'(loss);
      if (run_items != CNT_CEIL) run_items = run_items + 1'b1;
      if (last) begin
        total = run_total;
        // any mode other than mean closes the run as a sum
        if (mode == MODE_MEAN) total = total / ACC_W'(run_items);
        if (total > OUT_CEIL) total = OUT_CEIL;
        pending_losses.push_back('{total[OUT_W-1:0], 1'b1});
        run_total = '0;
        run_items = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    loss_result_t seen;
    loss_result_t want;
    if (!rst_n) begin
      mode      = MODE_NONE;
      run_total = '0;
      run_items = '0;
      pending_losses.delete();
    end else begin
      if (res.valid && res.ready) begin
        seen = '{res.loss_value, res.is_reduced};
        if (pending_losses.size() == 0) begin
          report_mismatch($sformatf("unexpected result loss=%0d reduced=%0b",
                                    seen.loss_value, seen.is_reduced));
        end else begin
          want = pending_losses.pop_front();
          if (seen.loss_value !== want.loss_value)
            report_mismatch($sformatf("loss_value %0d, expected %0d",
                                      seen.loss_value, want.loss_value));
          if (seen.is_reduced !== want.is_reduced)
            report_mismatch($sformatf("is_reduced %0b, expected %0b",
                                      seen.is_reduced, want.is_reduced));
        end
      end
      if (req.valid && req.ready)
        predict_request(req.logit_value, req.target_value, req.last_item);
      if (cfg.valid && cfg.ready) mode = cfg.data;
      if (end_of_run && !leftovers_flagged && pending_losses.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", pending_losses.size()));
        leftovers_flagged = 1'b1;
      end
    end
    fail_count <= fails;
    losses_due <= pending_losses.size();
  end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the BCE-with-logits loss unit: a directed pass over field
// extremes, target saturation, softplus reach and every reduction mode, then
// random requests in runs under three idling profiles, with mode changes
// between segments and runs left open across them. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import bcewl_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;
  localparam int                DRAIN_CYCLES = 16;
  localparam int                FLUSH_CYCLES = 64;
  localparam int                SEG_REQUESTS = 54;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        end_of_run;
  int unsigned fail_count;
  int unsigned losses_due;
  int          send_idle_pct;
  int          recv_idle_pct;

  bcewl_in_if  req_if();
  bcewl_out_if res_if();
  bcewl_cfg_if cfg_if();

  bce_with_logits_loss_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if),
    .cfg_ch (cfg_if)
  );

  bcewl_loss_checker loss_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_if),
    .res        (res_if),
    .cfg        (cfg_if),
    .end_of_run (end_of_run),
    .fail_count (fail_count),
    .losses_due (losses_due)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [MODE_W-1:0] mode_for(input int n);
    case (n % 4)
      0:       return MODE_NONE;
      1:       return MODE_SUM;
      2:       return MODE_MEAN;
      default: return MODE_SPARE;
    endcase
  endfunction

  function automatic logic signed [LOGIT_W-1:0] rand_logit();
    case ($urandom_range(7))
      0, 1: return LOGIT_W'($urandom);
      2: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return LOGIT_W'(int'($urandom_range(3400)) - 1700);
    endcase
  endfunction

  function automatic logic [TARGET_W-1:0] rand_target();
    case ($urandom_range(9))
      0:       return TARGET_W'($urandom_range(511, 257));
      1:       return TARGET_ONE;
      2:       return '0;
      default: return TARGET_W'($urandom_range(256));
    endcase
  endfunction

  task automatic send_request(input logic signed [LOGIT_W-1:0] x,
                              input logic [TARGET_W-1:0] y, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid        <= 1'b1;
    req_if.logit_value  <= x;
    req_if.target_value <= y;
    req_if.last_item    <= last;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_run(input int len, input bit closed);
    for (int i = 0; i < len; i++)
      send_request(rand_logit(), rand_target(), closed && (i == len - 1));
  endtask

  task automatic drain_results(input int settle);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (losses_due != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_reduction(input logic [MODE_W-1:0] m);
    drain_results(DRAIN_CYCLES);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int sent;
    int run_len;
    rst_n               <= 1'b0;
    end_of_run          <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.logit_value  <= '0;
    req_if.target_value <= '0;
    req_if.last_item    <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // per-element: extremes, target above one, softplus reach
    send_request(16'sh8000, 9'd256, 1'b0);
    send_request(16'sh8000, 9'd0,   1'b1);
    send_request(16'sh7FFF, 9'd0,   1'b0);
    send_request(16'sh7FFF, 9'd511, 1'b0);
    send_request(16'sh0000, 9'd0,   1'b0);
    send_request(16'shFFFF, 9'd257, 1'b1);
    send_request(16'sh0001, 9'd128, 1'b0);
    send_request(16'sh063F, 9'd64,  1'b0);
    send_request(16'sh0640, 9'd64,  1'b0);
    send_request(16'shF001, 9'd300, 1'b0);
    send_request(16'sh1000, 9'd200, 1'b0);

    set_reduction(MODE_SUM);
    send_request(16'sh8000, 9'd256, 1'b0);
    send_request(16'sh7FFF, 9'd0,   1'b0);
    send_request(16'sh0100, 9'd100, 1'b1);

    // unused mode closes as a sum
    set_reduction(MODE_SPARE);
    send_request(16'shFF00, 9'd10,  1'b0);
    send_request(16'sh0000, 9'd511, 1'b1);

    set_reduction(MODE_MEAN);
    send_request(16'sh0200, 9'd0,   1'b0);
    send_request(16'shFE00, 9'd256, 1'b0);
    send_request(16'sh0033, 9'd77,  1'b1);
    send_request(16'sh8000, 9'd256, 1'b1);

    // run opened as a sum and closed as a mean
    set_reduction(MODE_SUM);
    send_request(16'sh0500, 9'd0,   1'b0);
    send_request(16'shFB00, 9'd256, 1'b0);
    set_reduction(MODE_MEAN);
    send_request(16'sh0010, 9'd128, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 17 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        set_reduction(mode_for(seg + phase));
        sent = 0;
        while (sent < SEG_REQUESTS) begin
          run_len = ($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
          send_run(run_len, 1'b1);
          sent += run_len;
        end
        // leave a run open across the next mode change
        if ($urandom_range(1) == 1) send_run($urandom_range(3, 1), 1'b0);
      end
    end

    drain_results(FLUSH_CYCLES);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bcewl_pkg.sv
hw/rtl/bcewl_if.sv
hw/rtl/bcewl_front.sv
hw/rtl/bcewl_queue.sv
hw/rtl/bcewl_div.sv
hw/rtl/bcewl_back.sv
hw/rtl/bce_with_logits_loss_unit.sv
test/bcewl_loss_checker.sv
test/tb_top.sv
